// ----- sv/decimal_fixed_point_add_sub_macros.svh -----
// Assertion macros for the decimal fixed-point adder/subtractor.
`ifndef DECIMAL_FIXED_POINT_ADD_SUB_MACROS_SVH
`define DECIMAL_FIXED_POINT_ADD_SUB_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define DFPAS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DFPAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DFPAS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DFPAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/dfpas_pkg.sv -----
// Types and constants shared by the decimal fixed-point adder/subtractor.
`default_nettype none

package dfpas_pkg;

  localparam int NUM_LIMBS = 4;
  localparam int LIMB_W    = 30;
  localparam int FLAG_W    = 3;
  localparam int SUM_W     = LIMB_W + 3;  // limb sum, signed after base offset
  localparam int DIF_W     = LIMB_W + 1;  // signed limb difference
  localparam int DIFB_W    = LIMB_W + 2;  // signed difference plus base

  localparam logic [LIMB_W-1:0] LIMB_BASE = 30'd1000000000;

  localparam logic [FLAG_W-1:0] FLAG_NEG = 3'd1;
  localparam logic [FLAG_W-1:0] FLAG_INF = 3'd2;
  localparam logic [FLAG_W-1:0] FLAG_NAN = 3'd4;

  // Operation codes carried in the kind field.
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_SUB = 1'b1;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_SUB  = 2'd2;

  typedef logic [LIMB_W-1:0] limb_t;
  // Index 0 is the most significant limb.
  typedef limb_t [0:NUM_LIMBS-1] limbs_t;

  typedef struct packed {
    logic              kind;
    logic [FLAG_W-1:0] a_flags;
    limb_t             a_limb_int_hi;
    limb_t             a_limb_int_lo;
    limb_t             a_limb_frac_hi;
    limb_t             a_limb_frac_lo;
    logic [FLAG_W-1:0] b_flags;
    limb_t             b_limb_int_hi;
    limb_t             b_limb_int_lo;
    limb_t             b_limb_frac_hi;
    limb_t             b_limb_frac_lo;
  } req_t;

  typedef struct packed {
    logic [FLAG_W-1:0] sum_flags;
    limb_t             sum_limb_int_hi;
    limb_t             sum_limb_int_lo;
    limb_t             sum_limb_frac_hi;
    limb_t             sum_limb_frac_lo;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              neg;
    logic [FLAG_W-1:0] flags;
    limbs_t            limbs;
  } ctrl_t;

  // Candidate results of one lane for every possible carry or borrow in.
  typedef struct packed {
    limb_t [2:0]      add_d;
    logic  [2:0][1:0] add_c;
    limb_t [1:0]      xy_d;
    logic  [1:0]      xy_b;
    limb_t [1:0]      yx_d;
    logic  [1:0]      yx_b;
    logic             eq;
    logic             lt;
  } lane_res_t;

  typedef lane_res_t [0:NUM_LIMBS-1] lane_vec_t;

endpackage

`default_nettype wire

// ----- sv/dfpas_lane.sv -----
// One limb lane: sums, differences and carry-select candidates over two stages.
`default_nettype none

module dfpas_lane import dfpas_pkg::*; (
  input  logic      clk,
  input  logic      en1,
  input  logic      en2,
  input  limb_t     x,
  input  limb_t     y,
  output lane_res_t res
);

  localparam logic [SUM_W-1:0]  BASE_S  = SUM_W'(LIMB_BASE);
  localparam logic [SUM_W-1:0]  BASE2_S = BASE_S + BASE_S;
  localparam logic [DIFB_W-1:0] BASE_D  = DIFB_W'(LIMB_BASE);

  logic [SUM_W-1:0]  s_cmb;
  logic [DIF_W-1:0]  dxy_cmb, dyx_cmb;
  logic [SUM_W-1:0]  s0, s1, s2;
  logic [DIF_W-1:0]  dxy, dyx;
  logic [DIFB_W-1:0] dxyb, dyxb;
  logic              eq1, lt1;
  lane_res_t         res_next;

  assign s_cmb   = SUM_W'(x) + SUM_W'(y);
  assign dxy_cmb = DIF_W'(x) - DIF_W'(y);
  assign dyx_cmb = DIF_W'(y) - DIF_W'(x);

  always_ff @(posedge clk) begin
    if (en1) begin
      s0   <= s_cmb;
      s1   <= s_cmb - BASE_S;
      s2   <= s_cmb - BASE2_S;
      dxy  <= dxy_cmb;
      dyx  <= dyx_cmb;
      dxyb <= {dxy_cmb[DIF_W-1], dxy_cmb} + BASE_D;
      dyxb <= {dyx_cmb[DIF_W-1], dyx_cmb} + BASE_D;
      eq1  <= (x == y);
      lt1  <= (x < y);
    end
  end

  // Reduce the sum for carry in 0, 1, 2 and the differences for borrow 0, 1.
  always_comb begin
    logic [SUM_W-1:0]  u0, u1, u2;
    logic [DIF_W-1:0]  v;
    logic [DIFB_W-1:0] w;
    res_next = '0;
    for (int k = 0; k < 3; k++) begin
      u0 = s0 + SUM_W'(k);
      u1 = s1 + SUM_W'(k);
      u2 = s2 + SUM_W'(k);
      if (!u2[SUM_W-1]) begin
        res_next.add_d[k] = u2[LIMB_W-1:0];
        res_next.add_c[k] = 2'd2;
      end else if (!u1[SUM_W-1]) begin
        res_next.add_d[k] = u1[LIMB_W-1:0];
        res_next.add_c[k] = 2'd1;
      end else begin
        res_next.add_d[k] = u0[LIMB_W-1:0];
        res_next.add_c[k] = 2'd0;
      end
    end
    for (int k = 0; k < 2; k++) begin
      v = dxy - DIF_W'(k);
      w = dxyb - DIFB_W'(k);
      res_next.xy_d[k] = v[DIF_W-1] ? w[LIMB_W-1:0] : v[LIMB_W-1:0];
      res_next.xy_b[k] = v[DIF_W-1];
      v = dyx - DIF_W'(k);
      w = dyxb - DIFB_W'(k);
      res_next.yx_d[k] = v[DIF_W-1] ? w[LIMB_W-1:0] : v[LIMB_W-1:0];
      res_next.yx_b[k] = v[DIF_W-1];
    end
    res_next.eq = eq1;
    res_next.lt = lt1;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dfpas_merge.sv -----
// Merge stage: resolve carries and borrows across lanes and form the result.
`default_nettype none

module dfpas_merge import dfpas_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  ctrl_t     ctrl,
  input  lane_vec_t lanes,
  output rsp_t      rsp
);

  rsp_t rsp_next;

  always_comb begin
    logic [1:0]        c;
    logic              bw, found, swap;
    limbs_t            ad, sd, r;
    logic [FLAG_W-1:0] f;
    // Ripple the carry select from the least significant lane up.
    c  = 2'd0;
    ad = '0;
    for (int i = NUM_LIMBS - 1; i >= 0; i--) begin
      case (c)
        2'd2: begin
          ad[i] = lanes[i].add_d[2];
          c     = lanes[i].add_c[2];
        end
        2'd1: begin
          ad[i] = lanes[i].add_d[1];
          c     = lanes[i].add_c[1];
        end
        default: begin
          ad[i] = lanes[i].add_d[0];
          c     = lanes[i].add_c[0];
        end
      endcase
    end
    // The first differing limb from the top decides which operand is larger.
    found = 1'b0;
    swap  = 1'b0;
    for (int i = 0; i < NUM_LIMBS; i++) begin
      if (!found && !lanes[i].eq) begin
        swap  = lanes[i].lt;
        found = 1'b1;
      end
    end
    bw = 1'b0;
    sd = '0;
    for (int i = NUM_LIMBS - 1; i >= 0; i--) begin
      if (swap) begin
        sd[i] = bw ? lanes[i].yx_d[1] : lanes[i].yx_d[0];
        bw    = bw ? lanes[i].yx_b[1] : lanes[i].yx_b[0];
      end else begin
        sd[i] = bw ? lanes[i].xy_d[1] : lanes[i].xy_d[0];
        bw    = bw ? lanes[i].xy_b[1] : lanes[i].xy_b[0];
      end
    end
    case (ctrl.mode)
      MODE_ADD: begin
        if (c != 2'd0) begin
          r = '0;
          f = ctrl.neg ? (FLAG_INF | FLAG_NEG) : FLAG_INF;
        end else begin
          r = ad;
          f = (ctrl.neg && (ad != '0)) ? FLAG_NEG : '0;
        end
      end
      MODE_SUB: begin
        r = sd;
        f = (swap && (sd != '0)) ? FLAG_NEG : '0;
      end
      default: begin
        r = ctrl.limbs;
        f = ctrl.flags;
      end
    endcase
    rsp_next.sum_flags        = f;
    rsp_next.sum_limb_int_hi  = r[0];
    rsp_next.sum_limb_int_lo  = r[1];
    rsp_next.sum_limb_frac_hi = r[2];
    rsp_next.sum_limb_frac_lo = r[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/decimal_fixed_point_add_sub.sv -----
// Throughput: one transaction per cycle unless rsp_ready stalls the output; four
// limb lanes work in parallel and the carry/borrow ripple across lanes is resolved
// on narrow codes in the merge stage. Each stage advances whenever the stage after
// it is empty or moving, so bubbles are absorbed while a finished result waits.
// Reset: rst (synchronous) clears the three stage valid bits; payload is not reset.
`default_nettype none
`include "decimal_fixed_point_add_sub_macros.svh"

module decimal_fixed_point_add_sub import dfpas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Stage valid bits and per-stage advance enables.
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3       = !v3 || rsp_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;
  assign rsp_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Classification of the operands. Special values and the cases where one
  // magnitude is all zero bypass the lanes and ride along as a ready result.
  limbs_t a_l, b_l, x_l, y_l;
  logic   a_lz, b_lz, x_lz, y_lz;
  logic   a_zero, b_zero, nan, a_inf, b_inf, sa, sb, sub;
  ctrl_t  ctrl_next, ctrl1, ctrl2;

  assign a_l = {req.a_limb_int_hi, req.a_limb_int_lo, req.a_limb_frac_hi, req.a_limb_frac_lo};
  assign b_l = {req.b_limb_int_hi, req.b_limb_int_lo, req.b_limb_frac_hi, req.b_limb_frac_lo};

  assign sub    = (req.kind == KIND_SUB);
  assign a_lz   = (a_l == '0);
  assign b_lz   = (b_l == '0);
  assign a_zero = a_lz && (req.a_flags == '0);
  assign b_zero = b_lz && (req.b_flags == '0);
  assign nan    = |((req.a_flags | req.b_flags) & FLAG_NAN);
  assign a_inf  = |(req.a_flags & FLAG_INF);
  assign b_inf  = |(req.b_flags & FLAG_INF);
  assign sa     = |(req.a_flags & FLAG_NEG);
  assign sb     = (|(req.b_flags & FLAG_NEG)) ^ sub;

  // Unlike signs: subtract from the positive operand the negative one.
  assign x_l  = sa ? b_l : a_l;
  assign y_l  = sa ? a_l : b_l;
  assign x_lz = sa ? b_lz : a_lz;
  assign y_lz = sa ? a_lz : b_lz;

  always_comb begin
    ctrl_next.mode  = MODE_PASS;
    ctrl_next.neg   = sa;
    ctrl_next.flags = '0;
    ctrl_next.limbs = '0;
    if (nan) begin
      ctrl_next.flags = FLAG_NAN;
    end else if (b_zero || a_inf) begin
      ctrl_next.flags = req.a_flags;
      ctrl_next.limbs = a_l;
    end else if (a_zero || b_inf) begin
      // b is not zero here, so negation always flips its sign.
      ctrl_next.flags = sub ? (req.b_flags ^ FLAG_NEG) : req.b_flags;
      ctrl_next.limbs = b_l;
    end else if (sa == sb) begin
      if (b_lz) begin
        ctrl_next.flags = (sa && !a_lz) ? FLAG_NEG : '0;
        ctrl_next.limbs = a_l;
      end else if (a_lz) begin
        ctrl_next.flags = sa ? FLAG_NEG : '0;
        ctrl_next.limbs = b_l;
      end else begin
        ctrl_next.mode = MODE_ADD;
      end
    end else begin
      if (y_lz) begin
        ctrl_next.limbs = x_l;
      end else if (x_lz) begin
        ctrl_next.flags = FLAG_NEG;
        ctrl_next.limbs = y_l;
      end else begin
        ctrl_next.mode = MODE_SUB;
      end
    end
  end

  // Hold the control word alongside the lane pipeline.
  always_ff @(posedge clk) begin
    if (en1) ctrl1 <= ctrl_next;
    if (en2) ctrl2 <= ctrl1;
  end

  // Lanes: one per limb, two register stages each.
  lane_vec_t lane_res;

  for (genvar i = 0; i < NUM_LIMBS; i++) begin : g_lane
    dfpas_lane u_lane (
      .clk (clk),
      .en1 (en1),
      .en2 (en2),
      .x   (x_l[i]),
      .y   (y_l[i]),
      .res (lane_res[i])
    );
  end

  // Merge: carry and borrow resolution, sign and overflow, output register.
  dfpas_merge u_merge (
    .clk   (clk),
    .en    (en3),
    .ctrl  (ctrl2),
    .lanes (lane_res),
    .rsp   (rsp)
  );

  `DFPAS_ASSERT_NEXT(a_accept_fills, clk, rst, req_valid && req_ready, v1, "transaction lost")
  `DFPAS_ASSERT_IMPL(a_empty_ready, clk, rst, !v1, req_ready, "empty stage one not ready")
  `DFPAS_ASSERT_NEXT(a_s1_hold, clk, rst, v1 && !en2, v1 && $stable(ctrl1), "stage one not held")
  `DFPAS_ASSERT_NEXT(a_s2_hold, clk, rst, v2 && !en3, v2 && $stable(ctrl2), "stage two not held")

endmodule

`default_nettype wire
